// ----- hw/rtl/mst_pkg.sv -----
// Shared types and constants of the message subscription table.
package mst_pkg;

  // Field widths of table entries, commands and results
  localparam int unsigned MsgW   = 16;
  localparam int unsigned CompW  = 8;
  localparam int unsigned TagW   = 8;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned StatW  = 2;

  // Most delivery results reported for one deliver command
  localparam int unsigned MaxDeliver = 32;
  localparam int unsigned DlvW       = $clog2(MaxDeliver + 1);

  typedef enum logic [CmdW-1:0] {
    CMD_REGISTER  = 3'd0,
    CMD_REM_ONE   = 3'd1,
    CMD_REM_OWNER = 3'd2,
    CMD_UPDATE    = 3'd3,
    CMD_DELIVER   = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE    = 2'd0,
    ST_DELIVER = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_SCAN,
    FSM_FLUSH
  } fsm_e;

  // One subscription, 41 bits
  typedef struct packed {
    logic [MsgW-1:0]  msg;
    logic             has_comp;
    logic [CompW-1:0] comp;
    logic [TagW-1:0]  handler;
    logic [TagW-1:0]  owner;
  } entry_t;

  // One command as taken from the input ports
  typedef struct packed {
    cmd_e             cmd;
    logic [MsgW-1:0]  msg;
    logic [CompW-1:0] comp;
    logic             any;
    logic [TagW-1:0]  handler;
    logic [TagW-1:0]  owner;
  } req_t;

  // Control broadcast to the row of cells
  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/mst_cell.sv -----
// One storage cell of the subscription ring: load from the controller or take the neighbour.
module mst_cell (
  input  logic                clk_i,
  input  mst_pkg::cell_ctrl_t ctrl_i,
  input  logic                sel_i,
  input  mst_pkg::entry_t     wdata_i,
  input  mst_pkg::entry_t     nbr_i,
  output mst_pkg::entry_t     entry_o
);
  import mst_pkg::*;

  entry_t entry_q;

  // Load the written entry when selected, otherwise advance from the neighbour on a shift, else hold
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr && sel_i) begin
      entry_q <= wdata_i;
    end else if (ctrl_i.shift) begin
      entry_q <= nbr_i;
    end
  end

  assign entry_o = entry_q;

endmodule

// ----- hw/rtl/mst_ctrl.sv -----
// Sequencer of the subscription table: command decode, ring walk and result output.
module mst_ctrl #(
  parameter int unsigned Depth = 32,
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  mst_pkg::req_t                req_i,
  input  mst_pkg::entry_t              head_i,
  output mst_pkg::cell_ctrl_t          cell_ctrl_o,
  output logic [IdxW-1:0]              wr_idx_o,
  output mst_pkg::entry_t              wdata_o,
  output logic                         strobe_o,
  output logic [mst_pkg::StatW-1:0]    status_o,
  output logic [mst_pkg::TagW-1:0]     handler_o,
  output logic [mst_pkg::TagW-1:0]     owner_o,
  output logic                         last_o
);
  import mst_pkg::*;

  fsm_e            state_q, state_d;
  req_t            req_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] len_q, len_d;
  logic [CntW-1:0] iter_q, iter_d;
  logic [DlvW-1:0] dlv_q, dlv_d;
  logic            hold_v_q, hold_v_d;
  entry_t          hold_q, hold_d;

  logic            strobe_q, strobe_d;
  status_e         status_q, status_d;
  logic [TagW-1:0] handler_q, handler_d;
  logic [TagW-1:0] owner_q, owner_d;
  logic            last_q, last_d;

  logic            scan_cmd;
  logic            own_eq;
  logic            msg_eq;
  logic            dlv_match;
  logic            keep;
  entry_t          new_entry;

  // Decode the command and compare the head entry
  assign scan_cmd = (req_q.cmd == CMD_REM_ONE) || (req_q.cmd == CMD_REM_OWNER) ||
                    (req_q.cmd == CMD_UPDATE) || (req_q.cmd == CMD_DELIVER);
  assign own_eq    = (head_i.owner == req_q.owner);
  assign msg_eq    = (head_i.msg == req_q.msg);
  assign dlv_match = msg_eq && (!head_i.has_comp || (head_i.comp == req_q.comp));

  always_comb begin
    new_entry.msg      = req_q.msg;
    new_entry.has_comp = !req_q.any;
    new_entry.comp     = req_q.any ? '0 : req_q.comp;
    new_entry.handler  = req_q.handler;
    new_entry.owner    = req_q.owner;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (start_i) state_d = FSM_EXEC;
      end
      FSM_EXEC: begin
        if (scan_cmd && (count_q != '0)) state_d = FSM_SCAN;
        else                             state_d = FSM_IDLE;
      end
      FSM_SCAN: begin
        if (iter_q == CntW'(1)) state_d = FSM_FLUSH;
      end
      FSM_FLUSH: state_d = FSM_IDLE;
      default:   state_d = FSM_IDLE;
    endcase
  end

  assign busy_o = (state_q != FSM_IDLE);

  // Datapath, ring control and results
  always_comb begin
    count_d     = count_q;
    len_d       = len_q;
    iter_d      = iter_q;
    dlv_d       = dlv_q;
    hold_v_d    = hold_v_q;
    hold_d      = hold_q;
    strobe_d    = 1'b0;
    status_d    = ST_DONE;
    handler_d   = '0;
    owner_d     = '0;
    last_d      = 1'b0;
    cell_ctrl_o = '0;
    wr_idx_o    = count_q[IdxW-1:0];
    wdata_o     = new_entry;
    keep        = 1'b1;

    unique case (state_q)
      FSM_IDLE: ;
      FSM_EXEC: begin
        if (req_q.cmd == CMD_REGISTER) begin
          strobe_d = 1'b1;
          last_d   = 1'b1;
          if (count_q == CntW'(Depth)) begin
            status_d = ST_FULL;
          end else begin
            cell_ctrl_o.wr = 1'b1;
            count_d        = count_q + CntW'(1);
          end
        end else if (scan_cmd && (count_q != '0)) begin
          iter_d   = count_q;
          len_d    = count_q;
          dlv_d    = '0;
          hold_v_d = 1'b0;
        end else begin
          // Empty table or unknown command: answer at once
          strobe_d = 1'b1;
          last_d   = 1'b1;
          status_d = (req_q.cmd == CMD_DELIVER) ? ST_NOMATCH : ST_DONE;
        end
      end
      FSM_SCAN: begin
        wdata_o = head_i;
        unique case (req_q.cmd)
          CMD_REM_ONE:   keep = !(own_eq && msg_eq);
          CMD_REM_OWNER: keep = !own_eq;
          CMD_UPDATE: begin
            if (own_eq && msg_eq) begin
              wdata_o.has_comp = 1'b1;
              wdata_o.comp     = req_q.comp;
            end
          end
          CMD_DELIVER: begin
            // Hold each match back one step so that the final one carries last
            if (dlv_match && (dlv_q != DlvW'(MaxDeliver))) begin
              if (hold_v_q) begin
                strobe_d  = 1'b1;
                status_d  = ST_DELIVER;
                handler_d = hold_q.handler;
                owner_d   = hold_q.owner;
              end
              hold_d   = head_i;
              hold_v_d = 1'b1;
              dlv_d    = dlv_q + DlvW'(1);
            end
          end
          default: ;
        endcase
        // Pop the head and push it back behind the unvisited entries
        cell_ctrl_o.shift = 1'b1;
        cell_ctrl_o.wr    = keep;
        wr_idx_o          = IdxW'(len_q - CntW'(1));
        if (!keep) len_d = len_q - CntW'(1);
        iter_d = iter_q - CntW'(1);
      end
      FSM_FLUSH: begin
        count_d  = len_q;
        strobe_d = 1'b1;
        last_d   = 1'b1;
        if (req_q.cmd == CMD_DELIVER) begin
          if (hold_v_q) begin
            status_d  = ST_DELIVER;
            handler_d = hold_q.handler;
            owner_d   = hold_q.owner;
          end else begin
            status_d = ST_NOMATCH;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      count_q  <= '0;
      len_q    <= '0;
      iter_q   <= '0;
      dlv_q    <= '0;
      hold_v_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      len_q    <= len_d;
      iter_q   <= iter_d;
      dlv_q    <= dlv_d;
      hold_v_q <= hold_v_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) req_q <= req_i;
    hold_q    <= hold_d;
    status_q  <= status_d;
    handler_q <= handler_d;
    owner_q   <= owner_d;
    last_q    <= last_d;
  end

  assign strobe_o  = strobe_q;
  assign status_o  = status_q;
  assign handler_o = handler_q;
  assign owner_o   = owner_q;
  assign last_o    = last_q;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count beyond table depth");

  a_len_covers_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_SCAN) |-> ((iter_q != '0) && (len_q >= iter_q)))
    else $error("ring walk length lost track of unvisited entries");

  a_mid_is_delivery: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && !last_q) |-> (status_q == ST_DELIVER))
    else $error("non-final result that is not a delivery");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && last_q) |-> (state_q == FSM_IDLE))
    else $error("final result shown while the item is still in work");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == FSM_EXEC))
    else $error("accepted command not taken into execution");
`endif

endmodule

// ----- hw/rtl/message_subscription_table_top.sv -----
// Top level of the message subscription table: ring of entry cells and its sequencer.
//
// Usage: drive a command on command_i and its fields, raise start; the command
// is taken at the clock edge where start is high and busy is low. Results come
// out on status_o, target_handler_o, target_owner_o and last_o, each marked
// by a single-cycle result_strobe_o; last_o marks the final result of the
// command. The receiver cannot stall, so every strobe is a transfer.
// Register and unknown commands, and any command on an empty table, give one
// result from the execute state alone, without a walk.
// Remove, update and deliver walk the ring once: the entries rotate through
// cell 0 at one entry per cycle in the scan state, each stored entry being
// visited once, and the flush state then gives the last result.
// A delivery result is held until the next match or the end of the walk, so
// the final one always carries last_o.
// The next command is taken no earlier than the edge that transfers the last
// result of the one before, so items never overlap.
// Reset empties the table at once (the count is cleared; cell contents are
// left as they are and are never read before being written).
module message_subscription_table_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [mst_pkg::CmdW-1:0]  command_i,
  input  logic [mst_pkg::MsgW-1:0]  msg_id_i,
  input  logic [mst_pkg::CompW-1:0] component_id_i,
  input  logic                      any_component_i,
  input  logic [mst_pkg::TagW-1:0]  handler_tag_i,
  input  logic [mst_pkg::TagW-1:0]  owner_tag_i,
  output logic                      result_strobe_o,
  output logic [mst_pkg::StatW-1:0] status_o,
  output logic [mst_pkg::TagW-1:0]  target_handler_o,
  output logic [mst_pkg::TagW-1:0]  target_owner_o,
  output logic                      last_o
);
  import mst_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  req_t            req;
  cell_ctrl_t      cell_ctrl;
  logic [IdxW-1:0] wr_idx;
  entry_t          wdata;
  entry_t          cell_q [TABLE_DEPTH];

  // Gather the command fields
  always_comb begin
    req.cmd     = cmd_e'(command_i);
    req.msg     = msg_id_i;
    req.comp    = component_id_i;
    req.any     = any_component_i;
    req.handler = handler_tag_i;
    req.owner   = owner_tag_i;
  end

  mst_ctrl #(
    .Depth (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req),
    .head_i      (cell_q[0]),
    .cell_ctrl_o (cell_ctrl),
    .wr_idx_o    (wr_idx),
    .wdata_o     (wdata),
    .strobe_o    (result_strobe_o),
    .status_o    (status_o),
    .handler_o   (target_handler_o),
    .owner_o     (target_owner_o),
    .last_o      (last_o)
  );

  // Row of cells, each advancing towards cell 0
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    entry_t nbr;
    if (k == TABLE_DEPTH - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_body
      assign nbr = cell_q[k+1];
    end

    mst_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .sel_i   (wr_idx == IdxW'(k)),
      .wdata_i (wdata),
      .nbr_i   (nbr),
      .entry_o (cell_q[k])
    );
  end

endmodule

// ----- tb/sv/subscription_checker.sv -----
// Checker for the subscription table: tracks the table contents and compares every result transfer.
module subscription_checker #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      busy,
  input  logic [mst_pkg::CmdW-1:0]  command_i,
  input  logic [mst_pkg::MsgW-1:0]  msg_id_i,
  input  logic [mst_pkg::CompW-1:0] component_id_i,
  input  logic                      any_component_i,
  input  logic [mst_pkg::TagW-1:0]  handler_tag_i,
  input  logic [mst_pkg::TagW-1:0]  owner_tag_i,
  input  logic                      result_strobe_o,
  input  logic [mst_pkg::StatW-1:0] status_o,
  input  logic [mst_pkg::TagW-1:0]  target_handler_o,
  input  logic [mst_pkg::TagW-1:0]  target_owner_o,
  input  logic                      last_o,
  output int                        fail_count_o,
  output int                        pending_count_o,
  output int                        delivery_count_o,
  output int                        full_count_o
);
  import mst_pkg::*;

  typedef struct packed {
    status_e         status;
    logic [TagW-1:0] handler;
    logic [TagW-1:0] owner;
    logic            last;
  } response_t;

  // Shadow copy of the subscription table
  entry_t    sub_table [TABLE_DEPTH];
  int        sub_count;

  response_t expected_responses[$];
  response_t want;
  int        errors     = 0;
  int        deliveries = 0;
  int        full_drops = 0;

  task automatic queue_response(input status_e st, input logic [TagW-1:0] handler,
                                input logic [TagW-1:0] owner, input logic last);
    response_t r;
    r.status  = st;
    r.handler = handler;
    r.owner   = owner;
    r.last    = last;
    expected_responses = {expected_responses, r};
  endtask

  task automatic report_field(input string name, input logic [7:0] exp_val,
                              input logic [7:0] act_val);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
    errors++;
  endtask

  // Apply one command to the shadow table and queue the responses it causes
  task automatic predict_table_op(input logic [CmdW-1:0] cmd, input logic [MsgW-1:0] msg,
                                  input logic [CompW-1:0] comp, input logic any,
                                  input logic [TagW-1:0] handler,
                                  input logic [TagW-1:0] owner);
    int        w;
    int        n;
    logic      hit;
    logic      send_done;
    logic      have_held;
    response_t held;
    send_done = 1'b1;
    have_held = 1'b0;
    held      = '0;
    n         = 0;
    case (cmd)
      CMD_REGISTER: begin
        if (sub_count >= TABLE_DEPTH) begin
          // Drop the entry when the table is full
          queue_response(ST_FULL, '0, '0, 1'b1);
          send_done = 1'b0;
        end else begin
          sub_table[sub_count].msg      = msg;
          sub_table[sub_count].has_comp = !any;
          sub_table[sub_count].comp     = any ? '0 : comp;
          sub_table[sub_count].handler  = handler;
          sub_table[sub_count].owner    = owner;
          sub_count++;
        end
      end
      CMD_REM_ONE, CMD_REM_OWNER: begin
        // Compact the table, keeping survivors in order
        w = 0;
        for (int r = 0; r < sub_count; r++) begin
          hit = (sub_table[r].owner == owner) &&
                (cmd == CMD_REM_OWNER || sub_table[r].msg == msg);
          if (!hit) begin
            sub_table[w] = sub_table[r];
            w++;
          end
        end
        sub_count = w;
      end
      CMD_UPDATE: begin
        for (int i = 0; i < sub_count; i++) begin
          if (sub_table[i].msg == msg && sub_table[i].owner == owner) begin
            sub_table[i].has_comp = 1'b1;
            sub_table[i].comp     = comp;
          end
        end
      end
      CMD_DELIVER: begin
        // Hold back each match until the next, so the final one carries last
        for (int i = 0; i < sub_count; i++) begin
          if (sub_table[i].msg == msg && n < MaxDeliver &&
              (!sub_table[i].has_comp || sub_table[i].comp == comp)) begin
            if (have_held) expected_responses = {expected_responses, held};
            held.status  = ST_DELIVER;
            held.handler = sub_table[i].handler;
            held.owner   = sub_table[i].owner;
            held.last    = 1'b0;
            have_held    = 1'b1;
            n++;
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          expected_responses = {expected_responses, held};
        end else begin
          queue_response(ST_NOMATCH, '0, '0, 1'b1);
        end
        send_done = 1'b0;
      end
      default: begin
        // Unknown command leaves the table alone
      end
    endcase
    if (send_done) queue_response(ST_DONE, '0, '0, 1'b1);
  endtask

  // Compare result transfers, then predict for a command transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sub_count = 0;
      expected_responses.delete();
    end else begin
      if (result_strobe_o) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: result with nothing expected, status %0h handler %0h owner %0h last %0b",
                   $time, status_o, target_handler_o, target_owner_o, last_o);
          errors++;
        end else begin
          want = expected_responses.pop_front();
          if (status_o !== want.status)
            report_field("status", 8'(want.status), 8'(status_o));
          if (target_handler_o !== want.handler)
            report_field("target_handler", want.handler, target_handler_o);
          if (target_owner_o !== want.owner)
            report_field("target_owner", want.owner, target_owner_o);
          if (last_o !== want.last) report_field("last", 8'(want.last), 8'(last_o));
          if (want.status == ST_DELIVER) deliveries++;
          if (want.status == ST_FULL) full_drops++;
        end
      end
      if (start && !busy) begin
        predict_table_op(command_i, msg_id_i, component_id_i, any_component_i,
                         handler_tag_i, owner_tag_i);
      end
    end
    fail_count_o     <= errors;
    pending_count_o  <= expected_responses.size();
    delivery_count_o <= deliveries;
    full_count_o     <= full_drops;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top of the subscription table: clock, reset, command stimulus and verdict.
module tb_top;
  import mst_pkg::*;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int          RandomItems = 225;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             start           = 1'b0;
  logic             busy;
  logic [CmdW-1:0]  command_i       = '0;
  logic [MsgW-1:0]  msg_id_i        = '0;
  logic [CompW-1:0] component_id_i  = '0;
  logic             any_component_i = 1'b0;
  logic [TagW-1:0]  handler_tag_i   = '0;
  logic [TagW-1:0]  owner_tag_i     = '0;
  logic             result_strobe_o;
  logic [StatW-1:0] status_o;
  logic [TagW-1:0]  target_handler_o;
  logic [TagW-1:0]  target_owner_o;
  logic             last_o;

  int fail_count;
  int pending_count;
  int delivery_count;
  int full_count;

  int sent_total = 0;
  int burst_left = 0;
  int cmd_count[8];

  message_subscription_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .msg_id_i        (msg_id_i),
    .component_id_i  (component_id_i),
    .any_component_i (any_component_i),
    .handler_tag_i   (handler_tag_i),
    .owner_tag_i     (owner_tag_i),
    .result_strobe_o (result_strobe_o),
    .status_o        (status_o),
    .target_handler_o(target_handler_o),
    .target_owner_o  (target_owner_o),
    .last_o          (last_o)
  );

  subscription_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .msg_id_i        (msg_id_i),
    .component_id_i  (component_id_i),
    .any_component_i (any_component_i),
    .handler_tag_i   (handler_tag_i),
    .owner_tag_i     (owner_tag_i),
    .result_strobe_o (result_strobe_o),
    .status_o        (status_o),
    .target_handler_o(target_handler_o),
    .target_owner_o  (target_owner_o),
    .last_o          (last_o),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count),
    .delivery_count_o(delivery_count),
    .full_count_o    (full_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    #5000000;
    $display("Timeout with %0d responses outstanding", pending_count);
    $display("RESULT: ERROR");
    $finish;
  end

  // Drive one command and hold it until the transfer; pace in bursts with gaps
  task automatic issue_command(input logic [CmdW-1:0] cmd, input logic [MsgW-1:0] msg,
                               input logic [CompW-1:0] comp, input logic any,
                               input logic [TagW-1:0] handler,
                               input logic [TagW-1:0] owner);
    int gap;
    if (burst_left == 0) begin
      start <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    command_i       <= cmd;
    msg_id_i        <= msg;
    component_id_i  <= comp;
    any_component_i <= any;
    handler_tag_i   <= handler;
    owner_tag_i     <= owner;
    start           <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent_total++;
    cmd_count[cmd]++;
  endtask

  initial begin
    logic [MsgW-1:0]  id_pool[6];
    logic [TagW-1:0]  owner_pool[4];
    logic [CompW-1:0] comp_pool[2];
    logic [CmdW-1:0]  cmd;
    int               scenario;
    int               steps;
    int               op;
    int               phase;
    int               rand_start;

    foreach (cmd_count[k]) cmd_count[k] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, field extremes, component matching, update, unknown codes
    issue_command(CMD_DELIVER,   16'hFFFF, 8'hFF, 1'b0, 8'h00, 8'h00);
    issue_command(CMD_REM_ONE,   16'hFFFF, 8'h00, 1'b0, 8'h00, 8'hFF);
    issue_command(CMD_REM_OWNER, 16'h0000, 8'h00, 1'b0, 8'h00, 8'hFF);
    issue_command(CMD_UPDATE,    16'hFFFF, 8'h01, 1'b0, 8'h00, 8'hFF);
    issue_command(CMD_REGISTER,  16'hFFFF, 8'hFF, 1'b0, 8'hFF, 8'hFF);
    issue_command(CMD_REGISTER,  16'h0000, 8'h00, 1'b1, 8'h00, 8'h00);
    issue_command(CMD_REGISTER,  16'hFFFF, 8'hC3, 1'b1, 8'h5A, 8'hA5);
    issue_command(CMD_REGISTER,  16'h1234, 8'h07, 1'b0, 8'h11, 8'h22);
    issue_command(CMD_DELIVER,   16'hFFFF, 8'hFF, 1'b0, 8'h00, 8'h00);
    issue_command(CMD_DELIVER,   16'hFFFF, 8'h00, 1'b0, 8'h00, 8'h00);
    issue_command(CMD_DELIVER,   16'h0000, 8'h55, 1'b0, 8'h00, 8'h00);
    issue_command(CMD_DELIVER,   16'h1234, 8'h08, 1'b0, 8'h00, 8'h00);
    issue_command(CMD_UPDATE,    16'h1234, 8'h08, 1'b0, 8'h00, 8'h22);
    issue_command(CMD_DELIVER,   16'h1234, 8'h08, 1'b0, 8'h00, 8'h00);
    issue_command(CMD_UPDATE,    16'h0000, 8'h03, 1'b1, 8'h00, 8'h00);
    issue_command(CMD_DELIVER,   16'h0000, 8'h55, 1'b0, 8'h00, 8'h00);
    issue_command(3'd5,          16'hFFFF, 8'hFF, 1'b1, 8'hFF, 8'hFF);
    issue_command(3'd6,          16'h0000, 8'h00, 1'b0, 8'h00, 8'h00);
    issue_command(3'd7,          16'hFFFF, 8'hFF, 1'b0, 8'hFF, 8'hA5);
    issue_command(CMD_DELIVER,   16'hFFFF, 8'hFF, 1'b0, 8'h00, 8'h00);
    issue_command(CMD_REM_ONE,   16'hFFFF, 8'h00, 1'b0, 8'h00, 8'hFF);
    issue_command(CMD_REM_OWNER, 16'h0000, 8'h00, 1'b0, 8'h00, 8'hA5);
    issue_command(CMD_DELIVER,   16'hFFFF, 8'hFF, 1'b0, 8'h00, 8'h00);
    issue_command(CMD_REM_OWNER, 16'h0000, 8'h00, 1'b0, 8'h00, 8'h22);
    issue_command(CMD_REM_OWNER, 16'h0000, 8'h00, 1'b0, 8'h00, 8'h00);

    // Random: mostly sessions on a small pool of ids and owners so that deliveries hit
    foreach (id_pool[k]) id_pool[k] = MsgW'($urandom);
    foreach (owner_pool[k]) owner_pool[k] = TagW'($urandom);
    foreach (comp_pool[k]) comp_pool[k] = CompW'($urandom);
    rand_start = sent_total;
    phase = 0;
    while (sent_total - rand_start < RandomItems) begin
      // Fill the table first so the full case is always reached
      scenario = (phase == 0) ? 9 : $urandom_range(0, 9);
      phase++;
      if ($urandom_range(0, 3) == 0) id_pool[$urandom_range(0, 5)] = MsgW'($urandom);
      case (scenario)
        0, 1, 2, 3, 4, 5: begin
          steps = $urandom_range(6, 14);
          repeat (steps) begin
            op = $urandom_range(0, 9);
            cmd = (op <= 3) ? CMD_REGISTER : (op <= 6) ? CMD_DELIVER :
                  (op == 7) ? CMD_UPDATE : (op == 8) ? CMD_REM_ONE : CMD_REM_OWNER;
            issue_command(cmd, id_pool[$urandom_range(0, 5)], comp_pool[$urandom_range(0, 1)],
                          1'($urandom_range(0, 1)), TagW'($urandom),
                          owner_pool[$urandom_range(0, 3)]);
          end
        end
        6, 7: begin
          // Noise: any code, any field values
          repeat (6) begin
            issue_command(CmdW'($urandom_range(0, 7)), MsgW'($urandom), CompW'($urandom),
                          1'($urandom_range(0, 1)), TagW'($urandom),
                          ($urandom_range(0, 1) != 0) ? owner_pool[$urandom_range(0, 3)]
                                                      : TagW'($urandom));
          end
        end
        8: begin
          // Drain the pool owners and try a removal that finds nothing
          foreach (owner_pool[k])
            issue_command(CMD_REM_OWNER, MsgW'($urandom), CompW'($urandom), 1'b0,
                          TagW'($urandom), owner_pool[k]);
          issue_command(CMD_REM_ONE, MsgW'($urandom), CompW'($urandom), 1'b0,
                        TagW'($urandom), TagW'($urandom));
        end
        default: begin
          // Overfill, deliver the common id, then empty again
          repeat (TABLE_DEPTH + 2) begin
            issue_command(CMD_REGISTER, id_pool[0], comp_pool[0], 1'($urandom_range(0, 1)),
                          TagW'($urandom), owner_pool[$urandom_range(0, 3)]);
          end
          issue_command(CMD_DELIVER, id_pool[0], comp_pool[0], 1'b0, 8'h00, 8'h00);
          foreach (owner_pool[k])
            issue_command(CMD_REM_OWNER, 16'h0000, 8'h00, 1'b0, 8'h00, owner_pool[k]);
        end
      endcase
    end
    start <= 1'b0;

    // Let the last results arrive, then allow for the walk latency
    repeat (2) @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Covered %0d commands: %0d register, %0d remove-one, %0d remove-owner, %0d update,",
             sent_total, cmd_count[CMD_REGISTER], cmd_count[CMD_REM_ONE],
             cmd_count[CMD_REM_OWNER], cmd_count[CMD_UPDATE]);
    $display("%0d deliver, %0d unknown; %0d delivery results and %0d table-full drops checked",
             cmd_count[CMD_DELIVER], cmd_count[5] + cmd_count[6] + cmd_count[7],
             delivery_count, full_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
